FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define TMPU_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds during reset.
`define TMPU_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: rtl/tmpu_pkg.sv
package tmpu_pkg;

  localparam int DEF_MAX_SECTIONS    = 256;
  localparam int DEF_MAX_SLICES      = 256;
  localparam int DEF_SINE_TABLE_BITS = 10;
  localparam int DEF_COORD_BITS      = 16;

  localparam int IDX_W      = 8;
  localparam int CNT_W      = 9;
  localparam int RAD_W      = 15;
  localparam int FIELD_W    = 16;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 16;
  localparam int SUM_W      = 34;

  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam int              ONE_Q14     = 16384;

  localparam logic [FIELD_W-1:0] RST_ORIGIN = '0;
  localparam logic [RAD_W-1:0]   RST_MAJOR  = 15'd256;
  localparam logic [RAD_W-1:0]   RST_MINOR  = 15'd64;
  localparam logic [CNT_W-1:0]   RST_COUNT  = 9'd16;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_ORIGIN_Z,
    REG_MAJOR_RADIUS,
    REG_MINOR_RADIUS,
    REG_SECTION_COUNT,
    REG_SLICE_COUNT
  } cfg_reg_e;

  typedef struct packed {
    logic [FIELD_W-1:0] here;
    logic [FIELD_W-1:0] next_slice;
    logic [FIELD_W-1:0] next_section;
    logic [FIELD_W-1:0] diagonal;
    logic               oor;
  } corner_t;

  // First-quadrant sine entry in Q1.14, evaluated at elaboration.
  function automatic logic [RAD_W-1:0] quarter_sine(input int q, input int table_bits);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint          sum;
    x   = (PI_HALF_Q30 * 64'(q)) >> (table_bits - 2);
    x2  = (x * x) >> 30;
    t   = x;
    sum = longint'(x);
    for (int k = 1; k <= 7; k++) begin
      t = (t * x2) >> 30;
      case (k)
        1: t = t / 6;
        2: t = t / 20;
        3: t = t / 42;
        4: t = t / 72;
        5: t = t / 110;
        6: t = t / 156;
        default: t = t / 210;
      endcase
      if ((k & 1) == 1) sum = sum - longint'(t);
      else              sum = sum + longint'(t);
    end
    if (sum < 0) sum = 0;
    sum = (sum + 32768) >>> 16;
    if (sum > ONE_Q14) sum = ONE_Q14;
    return RAD_W'(sum);
  endfunction

  function automatic logic [FIELD_W-1:0] sat_coord(input logic signed [SUM_W-1:0] v,
                                                   input int coord_bits);
    logic signed [SUM_W-1:0] hi;
    logic signed [SUM_W-1:0] lo;
    logic signed [SUM_W-1:0] r;
    hi = (SUM_W'(1) <<< (coord_bits - 1)) - SUM_W'(1);
    lo = -hi - SUM_W'(1);
    r  = v;
    if (r > hi) r = hi;
    if (r < lo) r = lo;
    return r[FIELD_W-1:0];
  endfunction

endpackage

FILE: rtl/tmpu_ifs.sv
interface tmpu_point_if;
  logic                          valid;
  logic                          ready;
  logic [tmpu_pkg::IDX_W-1:0]    section_index;
  logic [tmpu_pkg::IDX_W-1:0]    slice_index;
  modport source (output valid, section_index, slice_index, input ready);
  modport sink   (input valid, section_index, slice_index, output ready);
endinterface

interface tmpu_vertex_if;
  logic                               valid;
  logic                               ready;
  logic signed [tmpu_pkg::FIELD_W-1:0] pos_x;
  logic signed [tmpu_pkg::FIELD_W-1:0] pos_y;
  logic signed [tmpu_pkg::FIELD_W-1:0] pos_z;
  logic signed [tmpu_pkg::FIELD_W-1:0] norm_x;
  logic signed [tmpu_pkg::FIELD_W-1:0] norm_y;
  logic signed [tmpu_pkg::FIELD_W-1:0] norm_z;
  logic [tmpu_pkg::FIELD_W-1:0]        corner_here;
  logic [tmpu_pkg::FIELD_W-1:0]        corner_next_slice;
  logic [tmpu_pkg::FIELD_W-1:0]        corner_next_section;
  logic [tmpu_pkg::FIELD_W-1:0]        corner_diagonal;
  logic                               out_of_range;
  modport source (output valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, corner_here,
                  corner_next_slice, corner_next_section, corner_diagonal, out_of_range,
                  input ready);
  modport sink   (input valid, pos_x, pos_y, pos_z, norm_x, norm_y, norm_z, corner_here,
                  corner_next_slice, corner_next_section, corner_diagonal, out_of_range,
                  output ready);
endinterface

interface tmpu_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [tmpu_pkg::CFG_ADDR_W-1:0]   index;
  logic [tmpu_pkg::CFG_DATA_W-1:0]   data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/torus_mesh_point_unit.sv
// Torus mesh point unit: takes one grid point (section, slice) per clock and returns its
// Q8.8 position, Q1.14 unit normal and the four wrapped corner indices of its grid cell.
// Throughput is one point per clock unless the vertex side stalls; the pipeline depth is
// set by the angle phase divider, which resolves one quotient bit per stage.
// A stall on the vertex side freezes the whole pipeline; the point side is ready whenever
// the output register is empty or being drained. Configuration writes are taken at once.
module torus_mesh_point_unit #(
  parameter int MAX_SECTIONS    = tmpu_pkg::DEF_MAX_SECTIONS,
  parameter int MAX_SLICES      = tmpu_pkg::DEF_MAX_SLICES,
  parameter int SINE_TABLE_BITS = tmpu_pkg::DEF_SINE_TABLE_BITS,
  parameter int COORD_BITS      = tmpu_pkg::DEF_COORD_BITS
) (
  input  logic          clk,
  input  logic          rst,
  tmpu_point_if.sink    point,
  tmpu_vertex_if.source vertex,
  tmpu_cfg_if.sink      cfg
);

  localparam int FW  = tmpu_pkg::FIELD_W;
  localparam int CW  = tmpu_pkg::CNT_W;
  localparam int IW  = tmpu_pkg::IDX_W;
  localparam int RW  = tmpu_pkg::RAD_W;
  localparam int QB  = SINE_TABLE_BITS + 1;
  localparam int LAT = QB + 5;
  localparam int NC  = LAT - 1;

  logic signed [FW-1:0] origin_x;
  logic signed [FW-1:0] origin_y;
  logic signed [FW-1:0] origin_z;
  logic [RW-1:0]        major_radius;
  logic [RW-1:0]        minor_radius;
  logic [CW-1:0]        section_count;
  logic [CW-1:0]        slice_count;

  logic [CW-1:0] sec_n;
  logic [CW-1:0] sli_n;
  logic          en;
  logic [LAT-1:0] vld;

  logic [IW-1:0] a_i;
  logic [IW-1:0] a_j;
  logic [CW-1:0] a_ni;
  logic [CW-1:0] a_nj;
  logic          a_oor;
  logic [CW-1:0] in_ni;
  logic [CW-1:0] in_nj;

  logic [2*CW-1:0] row_here;
  logic [2*CW-1:0] row_next;
  tmpu_pkg::corner_t corner_pipe [NC];
  tmpu_pkg::corner_t corner_out;

  logic [SINE_TABLE_BITS-1:0] theta;
  logic [SINE_TABLE_BITS-1:0] phi;
  logic signed [FW-1:0] sin_t;
  logic signed [FW-1:0] cos_t;
  logic signed [FW-1:0] sin_p;
  logic signed [FW-1:0] cos_p;
  logic signed [FW-1:0] pos_x;
  logic signed [FW-1:0] pos_y;
  logic signed [FW-1:0] pos_z;
  logic signed [FW-1:0] norm_x;
  logic signed [FW-1:0] norm_y;
  logic signed [FW-1:0] norm_z;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      origin_x      <= tmpu_pkg::RST_ORIGIN;
      origin_y      <= tmpu_pkg::RST_ORIGIN;
      origin_z      <= tmpu_pkg::RST_ORIGIN;
      major_radius  <= tmpu_pkg::RST_MAJOR;
      minor_radius  <= tmpu_pkg::RST_MINOR;
      section_count <= tmpu_pkg::RST_COUNT;
      slice_count   <= tmpu_pkg::RST_COUNT;
    end else if (cfg.valid) begin
      unique case (tmpu_pkg::cfg_reg_e'(cfg.index))
        tmpu_pkg::REG_ORIGIN_X:      origin_x      <= cfg.data;
        tmpu_pkg::REG_ORIGIN_Y:      origin_y      <= cfg.data;
        tmpu_pkg::REG_ORIGIN_Z:      origin_z      <= cfg.data;
        tmpu_pkg::REG_MAJOR_RADIUS:  major_radius  <= cfg.data[RW-1:0];
        tmpu_pkg::REG_MINOR_RADIUS:  minor_radius  <= cfg.data[RW-1:0];
        tmpu_pkg::REG_SECTION_COUNT: section_count <= cfg.data[CW-1:0];
        tmpu_pkg::REG_SLICE_COUNT:   slice_count   <= cfg.data[CW-1:0];
        default: ;
      endcase
    end
  end

  // clamp counts to the configured maximum
  assign sec_n = (section_count > MAX_SECTIONS) ? CW'(MAX_SECTIONS) : section_count;
  assign sli_n = (slice_count > MAX_SLICES) ? CW'(MAX_SLICES) : slice_count;

  assign en          = !vld[LAT-1] || vertex.ready;
  assign point.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], point.valid};
    end
  end

  // wrap to zero at the end of the row or ring
  assign in_ni = (CW'(point.section_index) + CW'(1) == sec_n) ? '0
                                                              : CW'(point.section_index) + CW'(1);
  assign in_nj = (CW'(point.slice_index) + CW'(1) == sli_n) ? '0
                                                            : CW'(point.slice_index) + CW'(1);

  always_ff @(posedge clk) begin
    if (en) begin
      a_i   <= point.section_index;
      a_j   <= point.slice_index;
      a_ni  <= in_ni;
      a_nj  <= in_nj;
      a_oor <= (CW'(point.section_index) >= sec_n) || (CW'(point.slice_index) >= sli_n);
    end
  end

  assign row_here = (2*CW)'(a_i) * (2*CW)'(sli_n);
  assign row_next = (2*CW)'(a_ni) * (2*CW)'(sli_n);

  always_ff @(posedge clk) begin
    if (en) begin
      corner_pipe[0].here         <= FW'(row_here + (2*CW)'(a_j));
      corner_pipe[0].next_slice   <= FW'(row_here + (2*CW)'(a_nj));
      corner_pipe[0].next_section <= FW'(row_next + (2*CW)'(a_j));
      corner_pipe[0].diagonal     <= FW'(row_next + (2*CW)'(a_nj));
      corner_pipe[0].oor          <= a_oor;
      for (int k = 1; k < NC; k++) begin
        corner_pipe[k] <= corner_pipe[k-1];
      end
    end
  end

  assign corner_out = corner_pipe[NC-1];

  tmpu_phase_div #(.TABLE_BITS(SINE_TABLE_BITS)) u_div_theta (
    .clk   (clk),
    .en    (en),
    .idx   (a_i),
    .count (sec_n),
    .phase (theta)
  );

  tmpu_phase_div #(.TABLE_BITS(SINE_TABLE_BITS)) u_div_phi (
    .clk   (clk),
    .en    (en),
    .idx   (a_j),
    .count (sli_n),
    .phase (phi)
  );

  tmpu_sine_lut #(.TABLE_BITS(SINE_TABLE_BITS)) u_lut (
    .clk   (clk),
    .en    (en),
    .theta (theta),
    .phi   (phi),
    .sin_t (sin_t),
    .cos_t (cos_t),
    .sin_p (sin_p),
    .cos_p (cos_p)
  );

  tmpu_geom #(.COORD_BITS(COORD_BITS)) u_geom (
    .clk          (clk),
    .en           (en),
    .sin_t        (sin_t),
    .cos_t        (cos_t),
    .sin_p        (sin_p),
    .cos_p        (cos_p),
    .origin_x     (origin_x),
    .origin_y     (origin_y),
    .origin_z     (origin_z),
    .major_radius (major_radius),
    .minor_radius (minor_radius),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .norm_x       (norm_x),
    .norm_y       (norm_y),
    .norm_z       (norm_z)
  );

  // drop everything but the flag for an out-of-range point
  assign vertex.valid               = vld[LAT-1];
  assign vertex.out_of_range        = corner_out.oor;
  assign vertex.pos_x               = corner_out.oor ? '0 : pos_x;
  assign vertex.pos_y               = corner_out.oor ? '0 : pos_y;
  assign vertex.pos_z               = corner_out.oor ? '0 : pos_z;
  assign vertex.norm_x              = corner_out.oor ? '0 : norm_x;
  assign vertex.norm_y              = corner_out.oor ? '0 : norm_y;
  assign vertex.norm_z              = corner_out.oor ? '0 : norm_z;
  assign vertex.corner_here         = corner_out.oor ? '0 : corner_out.here;
  assign vertex.corner_next_slice   = corner_out.oor ? '0 : corner_out.next_slice;
  assign vertex.corner_next_section = corner_out.oor ? '0 : corner_out.next_section;
  assign vertex.corner_diagonal     = corner_out.oor ? '0 : corner_out.diagonal;

endmodule

FILE: rtl/tmpu_phase_div.sv
module tmpu_phase_div #(
  parameter int TABLE_BITS = tmpu_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                       clk,
  input  logic                       en,
  input  logic [tmpu_pkg::IDX_W-1:0] idx,
  input  logic [tmpu_pkg::CNT_W-1:0] count,
  output logic [TABLE_BITS-1:0]      phase
);

  localparam int QB = TABLE_BITS + 1;
  localparam int DW = tmpu_pkg::IDX_W + TABLE_BITS + 2;

  logic [DW-1:0] dividend;
  logic [DW-1:0] rem    [QB];
  logic [QB-1:0] quo    [QB];
  logic [DW-1:0] rem_in [QB];
  logic [QB-1:0] quo_in [QB];

  // round(idx * 2^B / count) == floor((idx * 2^(B+1) + count) / (2 * count))
  assign dividend = DW'({idx, {QB{1'b0}}}) + DW'(count);

  for (genvar s = 0; s < QB; s++) begin : g_bit
    localparam int B = QB - 1 - s;
    logic [DW-1:0] dsh;
    logic          ge;

    if (s == 0) begin : g_first
      assign rem_in[s] = dividend;
      assign quo_in[s] = '0;
    end else begin : g_rest
      assign rem_in[s] = rem[s-1];
      assign quo_in[s] = quo[s-1];
    end

    assign dsh = DW'({count, 1'b0}) << B;
    assign ge  = rem_in[s] >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem[s] <= ge ? rem_in[s] - dsh : rem_in[s];
        quo[s] <= quo_in[s] | (QB'(ge) << B);
      end
    end
  end

  assign phase = quo[QB-1][TABLE_BITS-1:0];

endmodule

FILE: rtl/tmpu_sine_lut.sv
module tmpu_sine_lut #(
  parameter int TABLE_BITS = tmpu_pkg::DEF_SINE_TABLE_BITS
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic [TABLE_BITS-1:0]               theta,
  input  logic [TABLE_BITS-1:0]               phi,
  output logic signed [tmpu_pkg::FIELD_W-1:0] sin_t,
  output logic signed [tmpu_pkg::FIELD_W-1:0] cos_t,
  output logic signed [tmpu_pkg::FIELD_W-1:0] sin_p,
  output logic signed [tmpu_pkg::FIELD_W-1:0] cos_p
);

  localparam int QUARTER = 1 << (TABLE_BITS - 2);
  localparam int FW      = tmpu_pkg::FIELD_W;

  logic [tmpu_pkg::RAD_W-1:0] sine_rom [QUARTER+1];
  logic [TABLE_BITS-1:0]      lane_phase [4];
  logic signed [FW-1:0]       lane_val   [4];

  for (genvar g = 0; g <= QUARTER; g++) begin : g_rom
    assign sine_rom[g] = tmpu_pkg::quarter_sine(g, TABLE_BITS);
  end

  assign lane_phase[0] = theta;
  assign lane_phase[1] = theta + TABLE_BITS'(QUARTER);
  assign lane_phase[2] = phi;
  assign lane_phase[3] = phi + TABLE_BITS'(QUARTER);

  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [1:0]            quad;
    logic [TABLE_BITS-2:0] off;
    logic [TABLE_BITS-2:0] addr;
    logic signed [FW-1:0]  mag;

    assign quad = lane_phase[l][TABLE_BITS-1:TABLE_BITS-2];
    assign off  = {1'b0, lane_phase[l][TABLE_BITS-3:0]};

    // mirror the quarter wave in the second and fourth quadrants
    always_comb begin
      case (quad) inside
        2'd0, 2'd2: addr = off;
        default:    addr = (TABLE_BITS-1)'(QUARTER) - off;
      endcase
    end

    assign mag         = $signed({1'b0, sine_rom[addr]});
    assign lane_val[l] = quad[1] ? -mag : mag;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_t <= lane_val[0];
      cos_t <= lane_val[1];
      sin_p <= lane_val[2];
      cos_p <= lane_val[3];
    end
  end

endmodule

FILE: rtl/tmpu_geom.sv
module tmpu_geom #(
  parameter int COORD_BITS = tmpu_pkg::DEF_COORD_BITS
) (
  input  logic                                clk,
  input  logic                                en,
  input  logic signed [tmpu_pkg::FIELD_W-1:0] sin_t,
  input  logic signed [tmpu_pkg::FIELD_W-1:0] cos_t,
  input  logic signed [tmpu_pkg::FIELD_W-1:0] sin_p,
  input  logic signed [tmpu_pkg::FIELD_W-1:0] cos_p,
  input  logic signed [tmpu_pkg::FIELD_W-1:0] origin_x,
  input  logic signed [tmpu_pkg::FIELD_W-1:0] origin_y,
  input  logic signed [tmpu_pkg::FIELD_W-1:0] origin_z,
  input  logic [tmpu_pkg::RAD_W-1:0]          major_radius,
  input  logic [tmpu_pkg::RAD_W-1:0]          minor_radius,
  output logic signed [tmpu_pkg::FIELD_W-1:0] pos_x,
  output logic signed [tmpu_pkg::FIELD_W-1:0] pos_y,
  output logic signed [tmpu_pkg::FIELD_W-1:0] pos_z,
  output logic signed [tmpu_pkg::FIELD_W-1:0] norm_x,
  output logic signed [tmpu_pkg::FIELD_W-1:0] norm_y,
  output logic signed [tmpu_pkg::FIELD_W-1:0] norm_z
);

  localparam int FW = tmpu_pkg::FIELD_W;
  localparam int PW = 32;
  localparam int XW = 48;
  localparam int SW = tmpu_pkg::SUM_W;
  localparam int ZW = 18;

  logic signed [PW-1:0] minor_s;

  // product stage
  logic signed [PW-1:0] ring1;
  logic signed [PW-1:0] zp1;
  logic signed [PW-1:0] nx1;
  logic signed [PW-1:0] ny1;
  logic signed [FW-1:0] st1;
  logic signed [FW-1:0] ct1;
  logic signed [FW-1:0] sp1;

  // ring scaling stage
  logic signed [XW-1:0] px2;
  logic signed [XW-1:0] py2;
  logic signed [FW-1:0] nx2;
  logic signed [FW-1:0] ny2;
  logic signed [ZW-1:0] zoff2;
  logic signed [FW-1:0] sp2;

  logic signed [PW-1:0] nx_rnd;
  logic signed [PW-1:0] ny_rnd;
  logic signed [PW-1:0] z_rnd;
  logic signed [XW-1:0] x_rnd;
  logic signed [XW-1:0] y_rnd;
  logic signed [SW-1:0] sum_x;
  logic signed [SW-1:0] sum_y;
  logic signed [SW-1:0] sum_z;

  assign minor_s = $signed(PW'(minor_radius));

  always_ff @(posedge clk) begin
    if (en) begin
      ring1 <= $signed(PW'({major_radius, 14'd0})) + minor_s * PW'(cos_p);
      zp1   <= minor_s * PW'(sin_p);
      nx1   <= PW'(sin_t) * PW'(cos_p);
      ny1   <= PW'(cos_t) * PW'(cos_p);
      st1   <= sin_t;
      ct1   <= cos_t;
      sp1   <= sin_p;
    end
  end

  // round half up: add half, arithmetic shift
  assign nx_rnd = (nx1 + PW'(32'sd8192)) >>> 14;
  assign ny_rnd = (ny1 + PW'(32'sd8192)) >>> 14;
  assign z_rnd  = (zp1 + PW'(32'sd8192)) >>> 14;

  always_ff @(posedge clk) begin
    if (en) begin
      px2   <= XW'(st1) * XW'(ring1);
      py2   <= XW'(ct1) * XW'(ring1);
      nx2   <= nx_rnd[FW-1:0];
      ny2   <= ny_rnd[FW-1:0];
      zoff2 <= z_rnd[ZW-1:0];
      sp2   <= sp1;
    end
  end

  assign x_rnd = (px2 + (XW'(1) <<< 27)) >>> 28;
  assign y_rnd = (py2 + (XW'(1) <<< 27)) >>> 28;
  assign sum_x = SW'(origin_x) + x_rnd[SW-1:0];
  assign sum_y = SW'(origin_y) + y_rnd[SW-1:0];
  assign sum_z = SW'(origin_z) + SW'(zoff2);

  always_ff @(posedge clk) begin
    if (en) begin
      pos_x  <= tmpu_pkg::sat_coord(sum_x, COORD_BITS);
      pos_y  <= tmpu_pkg::sat_coord(sum_y, COORD_BITS);
      pos_z  <= tmpu_pkg::sat_coord(sum_z, COORD_BITS);
      norm_x <= nx2;
      norm_y <= ny2;
      norm_z <= sp2;
    end
  end

endmodule

FILE: rtl/tmpu_checker.sv
`include "assert_macros.svh"

module tmpu_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] pos_x,
  input logic signed [15:0] pos_z,
  input logic signed [15:0] norm_x,
  input logic signed [15:0] norm_z,
  input logic [15:0]        corner_here,
  input logic [15:0]        corner_diagonal,
  input logic               out_of_range
);

  `TMPU_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(corner_here), "stalled vertex changed")
  `TMPU_ASSERT(a_ready_rule, clk, rst, in_ready == (!out_valid || out_ready), "point ready does not follow output drain")
  `TMPU_ASSERT(a_oor_zero, clk, rst, out_valid && out_of_range |-> pos_x == 16'sd0 && pos_z == 16'sd0 && norm_x == 16'sd0 && corner_diagonal == 16'd0, "out-of-range vertex carries data")
  `TMPU_ASSERT(a_norm_range, clk, rst, out_valid |-> norm_z <= 16'sd16384 && norm_z >= -16'sd16384 && norm_x <= 16'sd16384 && norm_x >= -16'sd16384, "normal outside unit range")

endmodule

bind torus_mesh_point_unit tmpu_checker u_tmpu_checker (
  .clk             (clk),
  .rst             (rst),
  .in_ready        (point.ready),
  .out_valid       (vertex.valid),
  .out_ready       (vertex.ready),
  .pos_x           (vertex.pos_x),
  .pos_z           (vertex.pos_z),
  .norm_x          (vertex.norm_x),
  .norm_z          (vertex.norm_z),
  .corner_here     (vertex.corner_here),
  .corner_diagonal (vertex.corner_diagonal),
  .out_of_range    (vertex.out_of_range)
);
